### src/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared constants of the sector cache directory
// Field widths, request kinds, status codes and register indexes.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int ENTRIES = 64;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int DEVICES = 32;
	localparam int DEV_W   = 5;
	localparam int LBA_W   = 32;
	localparam int CNT_W   = 8;
	localparam int AGE_W   = 64;
	localparam int RUN_W   = 16;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 4;
	localparam int CFG_W   = 16;
	localparam int CFGI_W  = 1;
	localparam int REC_W   = DEV_W + LBA_W + AGE_W;

	localparam logic [RUN_W-1:0] RUN_MAX       = 16'hFFFF;
	localparam logic [RUN_W-1:0] SEQ_THR_RESET = 16'd4;

	// request kinds
	localparam logic [KIND_W-1:0] K_RD_LOOKUP = 3'd0;
	localparam logic [KIND_W-1:0] K_RD_FILL   = 3'd1;
	localparam logic [KIND_W-1:0] K_WR_REQ    = 3'd2;
	localparam logic [KIND_W-1:0] K_WR_RETRY  = 3'd3;
	localparam logic [KIND_W-1:0] K_FL_PICK   = 3'd4;
	localparam logic [KIND_W-1:0] K_FL_DONE   = 3'd5;
	localparam logic [KIND_W-1:0] K_INV       = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] S_DONE      = 4'd0;
	localparam logic [STAT_W-1:0] S_HIT       = 4'd1;
	localparam logic [STAT_W-1:0] S_MISS      = 4'd2;
	localparam logic [STAT_W-1:0] S_ALLOC     = 4'd3;
	localparam logic [STAT_W-1:0] S_FULL      = 4'd4;
	localparam logic [STAT_W-1:0] S_WTHRU     = 4'd5;
	localparam logic [STAT_W-1:0] S_FL_START  = 4'd6;
	localparam logic [STAT_W-1:0] S_NONE_DIRTY = 4'd7;
	localparam logic [STAT_W-1:0] S_FL_FAIL   = 4'd8;

	// register indexes
	localparam logic [CFGI_W-1:0] CFG_ENABLE = 1'd0;
	localparam logic [CFGI_W-1:0] CFG_SEQ_THR = 1'd1;

endpackage

### src/scd_req_if.sv
// ----------------------------------------------------------------------------
// scd_req_if: request channel of the sector cache directory
// Valid/ready handshake carrying one directory request.
// ----------------------------------------------------------------------------
interface scd_req_if;
	logic                        valid;
	logic                        ready;
	logic [scd_pkg::KIND_W-1:0]  kind;
	logic [scd_pkg::DEV_W-1:0]   device_id;
	logic [scd_pkg::LBA_W-1:0]   lba;
	logic [scd_pkg::CNT_W-1:0]   num_sectors;
	logic [scd_pkg::SLOT_W-1:0]  slot;
	logic                        io_ok;

	modport source (output valid, kind, device_id, lba, num_sectors, slot, io_ok,
		input ready);
	modport sink (input valid, kind, device_id, lba, num_sectors, slot, io_ok,
		output ready);
endinterface

### src/scd_rsp_if.sv
// ----------------------------------------------------------------------------
// scd_rsp_if: response channel of the sector cache directory
// Valid/ready handshake carrying one directory answer.
// ----------------------------------------------------------------------------
interface scd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [scd_pkg::STAT_W-1:0]  status;
	logic [scd_pkg::SLOT_W-1:0]  entry_slot;
	logic [scd_pkg::DEV_W-1:0]   flush_device;
	logic [scd_pkg::LBA_W-1:0]   flush_lba;

	modport source (output valid, status, entry_slot, flush_device, flush_lba,
		input ready);
	modport sink (input valid, status, entry_slot, flush_device, flush_lba,
		output ready);
endinterface

### src/scd_ram.sv
// ----------------------------------------------------------------------------
// scd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/sector_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// sector_cache_directory_unit: tag directory of a write-back sector cache
// Associative lookup, victim choice, flush choice and range invalidation
// by one sequential scan over the entry RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | kind, device_id, lba, num_sectors, slot, io_ok
//  rsp     | out | valid/ready        | status, entry_slot, flush_device, flush_lba
//  cfg     | in  | cfg_we, no stall   | cfg_index, cfg_data
//
//  A request that needs the directory runs one scan of the entry RAM starting
//  at the victim cursor, one entry per cycle through a single key/age compare
//  unit, then passes through a drain state and a finish state. Requests
//  answered from the flags alone (bypassed reads, empty writes, flush done) skip the scan.
//  req.ready is high only when idle with the response register empty.
//  Reset clears all flags, the cursor, the clock and the detector at once.
// ----------------------------------------------------------------------------
module sector_cache_directory_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	scd_req_if.sink                       req,
	scd_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [scd_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [scd_pkg::CFG_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [3:0] A_DONE    = 4'd0;
	localparam logic [3:0] A_MISS    = 4'd1;
	localparam logic [3:0] A_FDONE   = 4'd2;
	localparam logic [3:0] A_LOOKUP  = 4'd3;
	localparam logic [3:0] A_FILL    = 4'd4;
	localparam logic [3:0] A_INSTALL = 4'd5;
	localparam logic [3:0] A_RETRY   = 4'd6;
	localparam logic [3:0] A_INV_WT  = 4'd7;
	localparam logic [3:0] A_INV     = 4'd8;
	localparam logic [3:0] A_PICK    = 4'd9;

	localparam int E = scd_pkg::ENTRIES;
	localparam int SW = scd_pkg::SLOT_W;

	logic [1:0] state_q;
	logic [3:0] act_q;

	logic [E-1:0] valid_q, dirty_q, flushing_q, rewritten_q;
	logic [SW-1:0] cursor_q;
	logic [scd_pkg::AGE_W-1:0] clock_q;
	logic enable_q;
	logic [scd_pkg::RUN_W-1:0] thr_q;

	logic [scd_pkg::DEVICES-1:0] have_last_q;
	logic [scd_pkg::RUN_W-1:0] run_len_q [scd_pkg::DEVICES];
	logic [scd_pkg::LBA_W-1:0] last_end_q [scd_pkg::DEVICES];

	// latched request
	logic [scd_pkg::DEV_W-1:0]  dev_q;
	logic [scd_pkg::LBA_W-1:0]  lba_q;
	logic [scd_pkg::CNT_W-1:0]  cnt_q;
	logic [SW-1:0]              slot_q;
	logic                       ok_q;

	// scan pipeline
	logic [SW-1:0] n_q;
	logic          vld_s1;
	logic [SW-1:0] idx_s1;

	// scan results
	logic          hit_q, inv_found_q, cand_found_q;
	logic [SW-1:0] hit_slot_q, inv_slot_q, cand_slot_q;
	logic [scd_pkg::AGE_W-1:0] cand_age_q;
	logic [scd_pkg::DEV_W-1:0] cand_dev_q;
	logic [scd_pkg::LBA_W-1:0] cand_lba_q;

	// response register
	logic                          out_valid_q;
	logic [scd_pkg::STAT_W-1:0]    out_status_q;
	logic [SW-1:0]                 out_slot_q;
	logic [scd_pkg::DEV_W-1:0]     out_dev_q;
	logic [scd_pkg::LBA_W-1:0]     out_lba_q;

	// entry RAM: {device, sector, age}
	logic                          ram_we;
	logic [SW-1:0]                 ram_waddr;
	logic [scd_pkg::REC_W-1:0]     ram_wdata, ram_rdata;
	logic [SW-1:0]                 ram_raddr;
	logic [scd_pkg::DEV_W-1:0]     rd_dev;
	logic [scd_pkg::LBA_W-1:0]     rd_sec;
	logic [scd_pkg::AGE_W-1:0]     rd_age;

	scd_ram #(.WIDTH(scd_pkg::REC_W), .DEPTH(E)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign {rd_dev, rd_sec, rd_age} = ram_rdata;
	assign ram_raddr = cursor_q + n_q;

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	logic accept;
	assign accept = req.valid && req.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.entry_slot   = out_slot_q;
	assign rsp.flush_device = out_dev_q;
	assign rsp.flush_lba    = out_lba_q;

	// sequential write detector, evaluated on the incoming request
	logic                      det_cont;
	logic [scd_pkg::RUN_W:0]   det_sum;
	logic [scd_pkg::RUN_W-1:0] det_run;
	logic                      det_through;
	always_comb begin
		det_cont = have_last_q[req.device_id] && (req.lba == last_end_q[req.device_id]);
		det_sum = {1'b0, run_len_q[req.device_id]} + (scd_pkg::RUN_W+1)'(req.num_sectors);
		if (!det_cont) begin
			det_run = scd_pkg::RUN_W'(req.num_sectors);
		end else if (det_sum > {1'b0, scd_pkg::RUN_MAX}) begin
			det_run = scd_pkg::RUN_MAX;
		end else begin
			det_run = det_sum[scd_pkg::RUN_W-1:0];
		end
		det_through = (req.num_sectors > scd_pkg::CNT_W'(1)) || (det_run >= thr_q);
	end

	// decode the action of an incoming request
	logic [3:0]                next_act;
	logic [scd_pkg::CNT_W-1:0] next_cnt;
	always_comb begin
		next_cnt = req.num_sectors;
		case (req.kind)
			scd_pkg::K_RD_LOOKUP: next_act = enable_q ? A_LOOKUP : A_MISS;
			scd_pkg::K_RD_FILL:   next_act = enable_q ? A_FILL : A_DONE;
			scd_pkg::K_WR_REQ: begin
				if (req.num_sectors == '0) begin
					next_act = A_DONE;
				end else if (!enable_q || det_through) begin
					next_act = A_INV_WT;
				end else begin
					next_act = A_INSTALL;
				end
			end
			scd_pkg::K_WR_RETRY: begin
				next_act = enable_q ? A_RETRY : A_INV_WT;
				next_cnt = scd_pkg::CNT_W'(1);
			end
			scd_pkg::K_FL_PICK: next_act = A_PICK;
			scd_pkg::K_FL_DONE: next_act = A_FDONE;
			scd_pkg::K_INV:     next_act = A_INV;
			default:            next_act = A_DONE;
		endcase
	end

	logic needs_scan;
	assign needs_scan = !(next_act == A_DONE || next_act == A_MISS || next_act == A_FDONE);

	// per-entry conditions of the shared compare unit
	logic v_s1, key_eq, in_range, cand_ok, cand_better, do_inv;
	logic is_alloc_act;
	assign is_alloc_act = (act_q == A_FILL) || (act_q == A_INSTALL) || (act_q == A_RETRY);
	always_comb begin
		v_s1 = valid_q[idx_s1];
		key_eq = (rd_dev == dev_q) && (rd_sec == lba_q);
		in_range = (rd_sec - lba_q) < scd_pkg::LBA_W'(cnt_q);
		if (act_q == A_PICK) begin
			cand_ok = v_s1 && dirty_q[idx_s1] && !flushing_q[idx_s1];
		end else begin
			cand_ok = v_s1 && !dirty_q[idx_s1] && !flushing_q[idx_s1] && is_alloc_act;
		end
		cand_better = !cand_found_q || (rd_age < cand_age_q) ||
			((rd_age == cand_age_q) && (idx_s1 < cand_slot_q));
		do_inv = vld_s1 && (act_q == A_INV_WT || act_q == A_INV) &&
			v_s1 && (rd_dev == dev_q) && in_range;
	end

	// finish decisions
	logic [scd_pkg::AGE_W-1:0] clock_inc;
	logic                      fin_victim;
	logic [SW-1:0]             fin_slot;
	assign clock_inc = clock_q + scd_pkg::AGE_W'(1);
	always_comb begin
		fin_victim = inv_found_q || cand_found_q;
		if (hit_q) begin
			fin_slot = hit_slot_q;
		end else if (inv_found_q) begin
			fin_slot = inv_slot_q;
		end else begin
			fin_slot = cand_slot_q;
		end
	end

	logic fin_touch;
	always_comb begin
		fin_touch = 1'b0;
		if (state_q == ST_FIN) begin
			if (act_q == A_LOOKUP) begin
				fin_touch = hit_q;
			end else if (is_alloc_act) begin
				fin_touch = hit_q || fin_victim;
			end
		end
	end

	assign ram_we    = fin_touch;
	assign ram_waddr = fin_slot;
	assign ram_wdata = {dev_q, lba_q, clock_inc};

	// response fields of the finishing transaction
	logic [scd_pkg::STAT_W-1:0] fin_status;
	logic [SW-1:0]              fin_out_slot;
	logic [scd_pkg::DEV_W-1:0]  fin_out_dev;
	logic [scd_pkg::LBA_W-1:0]  fin_out_lba;
	always_comb begin
		fin_out_slot = '0;
		fin_out_dev = '0;
		fin_out_lba = '0;
		case (act_q)
			A_DONE:  fin_status = scd_pkg::S_DONE;
			A_MISS:  fin_status = scd_pkg::S_MISS;
			A_FDONE: fin_status = ok_q ? scd_pkg::S_DONE : scd_pkg::S_FL_FAIL;
			A_LOOKUP: begin
				fin_status = hit_q ? scd_pkg::S_HIT : scd_pkg::S_MISS;
				fin_out_slot = hit_q ? hit_slot_q : '0;
			end
			A_FILL: begin
				if (hit_q) begin
					fin_status = scd_pkg::S_HIT;
					fin_out_slot = hit_slot_q;
				end else if (fin_victim) begin
					fin_status = scd_pkg::S_ALLOC;
					fin_out_slot = fin_slot;
				end else begin
					fin_status = scd_pkg::S_FULL;
				end
			end
			A_INSTALL, A_RETRY: begin
				if (hit_q || fin_victim) begin
					fin_status = scd_pkg::S_ALLOC;
					fin_out_slot = fin_slot;
				end else begin
					fin_status = (act_q == A_RETRY) ? scd_pkg::S_WTHRU
						: scd_pkg::S_FULL;
				end
			end
			A_INV_WT: fin_status = scd_pkg::S_WTHRU;
			A_INV:    fin_status = scd_pkg::S_DONE;
			A_PICK: begin
				if (cand_found_q) begin
					fin_status = scd_pkg::S_FL_START;
					fin_out_slot = cand_slot_q;
					fin_out_dev = cand_dev_q;
					fin_out_lba = cand_lba_q;
				end else begin
					fin_status = scd_pkg::S_NONE_DIRTY;
				end
			end
			default: fin_status = scd_pkg::S_DONE;
		endcase
	end

	// control, scan and finish sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= A_DONE;
			n_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q <= '0;
			dirty_q <= '0;
			flushing_q <= '0;
			rewritten_q <= '0;
			cursor_q <= '0;
			clock_q <= '0;
			enable_q <= 1'b1;
			thr_q <= scd_pkg::SEQ_THR_RESET;
			have_last_q <= '0;
			for (int d = 0; d < scd_pkg::DEVICES; d++) begin
				run_len_q[d] <= '0;
				last_end_q[d] <= '0;
			end
			hit_q <= 1'b0;
			inv_found_q <= 1'b0;
			cand_found_q <= 1'b0;
		end else begin
			// register writes
			if (cfg_we && cfg_index == scd_pkg::CFG_ENABLE) begin
				enable_q <= cfg_data[0];
			end
			if (cfg_we && cfg_index == scd_pkg::CFG_SEQ_THR) begin
				thr_q <= cfg_data;
			end

			// drop the response once taken
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q <= next_act;
						n_q <= '0;
						hit_q <= 1'b0;
						inv_found_q <= 1'b0;
						cand_found_q <= 1'b0;
						state_q <= needs_scan ? ST_SCAN : ST_FIN;
						// update the detector on a cached write request
						if (req.kind == scd_pkg::K_WR_REQ && enable_q &&
							req.num_sectors != '0) begin
							have_last_q[req.device_id] <= 1'b1;
							run_len_q[req.device_id] <= det_run;
							last_end_q[req.device_id] <= req.lba +
								scd_pkg::LBA_W'(req.num_sectors);
						end
					end
				end
				ST_SCAN: begin
					n_q <= n_q + SW'(1);
					if (n_q == SW'(E - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase

			// evaluate one entry through the shared compare unit
			if (vld_s1) begin
				if (v_s1 && key_eq) begin
					hit_q <= 1'b1;
				end
				if (!v_s1 && !inv_found_q) begin
					inv_found_q <= 1'b1;
				end
				if (cand_ok && cand_better) begin
					cand_found_q <= 1'b1;
				end
			end
			if (do_inv) begin
				valid_q[idx_s1] <= 1'b0;
				dirty_q[idx_s1] <= 1'b0;
				flushing_q[idx_s1] <= 1'b0;
				rewritten_q[idx_s1] <= 1'b0;
			end

			// apply the outcome
			if (state_q == ST_FIN) begin
				if (fin_touch) begin
					clock_q <= clock_inc;
				end
				if (is_alloc_act && !hit_q && inv_found_q) begin
					cursor_q <= inv_slot_q + SW'(1);
				end
				if (is_alloc_act && !hit_q && fin_victim) begin
					valid_q[fin_slot] <= 1'b1;
					dirty_q[fin_slot] <= (act_q != A_FILL);
					flushing_q[fin_slot] <= 1'b0;
					rewritten_q[fin_slot] <= (act_q != A_FILL);
				end
				if ((act_q == A_INSTALL || act_q == A_RETRY) && hit_q) begin
					dirty_q[fin_slot] <= 1'b1;
					rewritten_q[fin_slot] <= 1'b1;
				end
				if (act_q == A_PICK && cand_found_q) begin
					flushing_q[cand_slot_q] <= 1'b1;
					rewritten_q[cand_slot_q] <= 1'b0;
				end
				if (act_q == A_FDONE && valid_q[slot_q] && flushing_q[slot_q]) begin
					flushing_q[slot_q] <= 1'b0;
					if (ok_q && !rewritten_q[slot_q]) begin
						dirty_q[slot_q] <= 1'b0;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dev_q <= req.device_id;
			lba_q <= req.lba;
			cnt_q <= next_cnt;
			slot_q <= req.slot;
			ok_q <= req.io_ok;
		end
		idx_s1 <= ram_raddr;
		if (vld_s1) begin
			if (v_s1 && key_eq) begin
				hit_slot_q <= idx_s1;
			end
			if (!v_s1 && !inv_found_q) begin
				inv_slot_q <= idx_s1;
			end
			if (cand_ok && cand_better) begin
				cand_slot_q <= idx_s1;
				cand_age_q <= rd_age;
				cand_dev_q <= rd_dev;
				cand_lba_q <= rd_sec;
			end
		end
		if (state_q == ST_FIN) begin
			out_status_q <= fin_status;
			out_slot_q <= fin_out_slot;
			out_dev_q <= fin_out_dev;
			out_lba_q <= fin_out_lba;
		end
	end

	// an accepted transaction leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted transaction left the sequencer idle");

	// the finish cycle always loads a response
	a_fin_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> out_valid_q)
		else $error("finish cycle produced no response");

	// no new request while a response waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !req.ready)
		else $error("request accepted with response pending");

	// the scan hands over to the drain cycle after its last entry
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && n_q == SW'(E - 1)) |=> (state_q == ST_DRAIN && vld_s1))
		else $error("scan did not end in drain");

endmodule

### tb/scd_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_tb_if: testbench side of the directory channels
// The block's request and response interfaces come from the RTL source set;
// this file only gathers the transaction types that the testbench passes
// between its stimulus, driver and scoreboard.
// ----------------------------------------------------------------------------
package scd_tb_types;
	import scd_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DEV_W-1:0]  device_id;
		logic [LBA_W-1:0]  lba;
		logic [CNT_W-1:0]  num_sectors;
		logic [SLOT_W-1:0] slot;
		logic              io_ok;
	} dir_request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] entry_slot;
		logic [DEV_W-1:0]  flush_device;
		logic [LBA_W-1:0]  flush_lba;
	} dir_answer_t;
endpackage

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sector_cache_directory_unit
// Sends directed and random directory requests through a valid/ready driver,
// predicts each answer from a behavioral copy of the directory, and compares
// the answers one by one. Random gaps on both sides and one long response
// stall exercise backpressure; registers change between idle phases.
// ----------------------------------------------------------------------------
module testbench;
	import scd_pkg::*;
	import scd_tb_types::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int LONG_STALL     = 1500;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	scd_req_if req_ch ();
	scd_rsp_if rsp_ch ();

	sector_cache_directory_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// directory shadow
	logic             dir_valid [ENTRIES];
	logic             dir_dirty [ENTRIES];
	logic             dir_flushing [ENTRIES];
	logic             dir_rewritten [ENTRIES];
	logic [DEV_W-1:0] dir_dev [ENTRIES];
	logic [LBA_W-1:0] dir_sector [ENTRIES];
	logic [AGE_W-1:0] dir_age [ENTRIES];
	logic [SLOT_W-1:0] cursor;
	logic [AGE_W-1:0]  lru_clock;
	logic             seq_seen [DEVICES];
	logic [RUN_W-1:0] seq_run [DEVICES];
	logic [LBA_W-1:0] seq_end [DEVICES];
	logic             shadow_enable;
	logic [RUN_W-1:0] shadow_threshold;

	dir_request_t pending_requests [$];
	dir_answer_t  expected_answers [$];
	int errors;
	int sent_count;
	int answer_count;
	int hit_count;
	int flush_count;
	int idle_cycles;
	int send_wait;
	int take_wait;
	int hold_off;
	bit hold_armed;

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int match_slot(logic [DEV_W-1:0] dev, logic [LBA_W-1:0] lba);
		for (int i = 0; i < ENTRIES; i++)
			if (dir_valid[i] && dir_dev[i] == dev && dir_sector[i] == lba)
				return i;
		return -1;
	endfunction

	function automatic int choose_victim();
		int best;
		int idx;
		best = -1;
		for (int n = 0; n < ENTRIES; n++) begin
			idx = (int'(cursor) + n) % ENTRIES;
			if (!dir_valid[idx]) begin
				cursor = SLOT_W'((idx + 1) % ENTRIES);
				return idx;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (dir_dirty[i] || dir_flushing[i])
				continue;
			if (best < 0 || dir_age[i] < dir_age[best])
				best = i;
		end
		return best;
	endfunction

	function automatic void stamp(int s);
		lru_clock++;
		dir_age[s] = lru_clock;
	endfunction

	function automatic int claim_entry(logic [DEV_W-1:0] dev, logic [LBA_W-1:0] lba);
		int s;
		s = match_slot(dev, lba);
		if (s >= 0)
			return s;
		s = choose_victim();
		if (s < 0)
			return -1;
		dir_valid[s] = 1'b1;
		dir_dirty[s] = 1'b0;
		dir_flushing[s] = 1'b0;
		dir_rewritten[s] = 1'b0;
		dir_dev[s] = dev;
		dir_sector[s] = lba;
		return s;
	endfunction

	function automatic void drop_range(logic [DEV_W-1:0] dev, logic [LBA_W-1:0] lba,
			logic [CNT_W-1:0] cnt);
		logic [LBA_W-1:0] offs;
		for (int i = 0; i < ENTRIES; i++) begin
			offs = dir_sector[i] - lba;
			if (dir_valid[i] && dir_dev[i] == dev && offs < LBA_W'(cnt)) begin
				dir_valid[i] = 1'b0;
				dir_dirty[i] = 1'b0;
				dir_flushing[i] = 1'b0;
				dir_rewritten[i] = 1'b0;
			end
		end
	endfunction

	function automatic bit sequential_through(logic [DEV_W-1:0] dev,
			logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt);
		int unsigned run;
		run = cnt;
		if (dev < DEVICES) begin
			if (seq_seen[dev] && lba == seq_end[dev]) begin
				run = int'(seq_run[dev]) + cnt;
				if (run > 65535)
					run = 65535;
			end
			seq_run[dev] = RUN_W'(run);
			seq_seen[dev] = 1'b1;
			seq_end[dev] = lba + LBA_W'(cnt);
		end
		return cnt > 1 || run >= shadow_threshold;
	endfunction

	function automatic int install_dirty(logic [DEV_W-1:0] dev, logic [LBA_W-1:0] lba);
		int s;
		s = claim_entry(dev, lba);
		if (s < 0)
			return -1;
		stamp(s);
		dir_dirty[s] = 1'b1;
		dir_rewritten[s] = 1'b1;
		return s;
	endfunction

	// predict the answer of one request and advance the shadow directory
	function automatic dir_answer_t predict_answer(dir_request_t r);
		dir_answer_t a;
		int s;
		a = '0;
		case (r.kind)
			K_RD_LOOKUP: begin
				a.status = S_MISS;
				if (shadow_enable) begin
					s = match_slot(r.device_id, r.lba);
					if (s >= 0) begin
						stamp(s);
						a.status = S_HIT;
						a.entry_slot = SLOT_W'(s);
					end
				end
			end
			K_RD_FILL: begin
				if (shadow_enable) begin
					s = match_slot(r.device_id, r.lba);
					if (s >= 0) begin
						stamp(s);
						a.status = S_HIT;
						a.entry_slot = SLOT_W'(s);
					end else begin
						s = claim_entry(r.device_id, r.lba);
						if (s < 0) begin
							a.status = S_FULL;
						end else begin
							stamp(s);
							a.status = S_ALLOC;
							a.entry_slot = SLOT_W'(s);
						end
					end
				end
			end
			K_WR_REQ: begin
				if (r.num_sectors != 0) begin
					if (!shadow_enable ||
							sequential_through(r.device_id, r.lba, r.num_sectors)) begin
						drop_range(r.device_id, r.lba, r.num_sectors);
						a.status = S_WTHRU;
					end else begin
						s = install_dirty(r.device_id, r.lba);
						if (s < 0) begin
							a.status = S_FULL;
						end else begin
							a.status = S_ALLOC;
							a.entry_slot = SLOT_W'(s);
						end
					end
				end
			end
			K_WR_RETRY: begin
				s = shadow_enable ? install_dirty(r.device_id, r.lba) : -1;
				if (s < 0) begin
					drop_range(r.device_id, r.lba, CNT_W'(1));
					a.status = S_WTHRU;
				end else begin
					a.status = S_ALLOC;
					a.entry_slot = SLOT_W'(s);
				end
			end
			K_FL_PICK: begin
				s = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!dir_valid[i] || !dir_dirty[i] || dir_flushing[i])
						continue;
					if (s < 0 || dir_age[i] < dir_age[s])
						s = i;
				end
				if (s < 0) begin
					a.status = S_NONE_DIRTY;
				end else begin
					dir_flushing[s] = 1'b1;
					dir_rewritten[s] = 1'b0;
					a.status = S_FL_START;
					a.entry_slot = SLOT_W'(s);
					a.flush_device = dir_dev[s];
					a.flush_lba = dir_sector[s];
				end
			end
			K_FL_DONE: begin
				if (dir_valid[r.slot] && dir_flushing[r.slot]) begin
					dir_flushing[r.slot] = 1'b0;
					if (r.io_ok && !dir_rewritten[r.slot])
						dir_dirty[r.slot] = 1'b0;
				end
				a.status = r.io_ok ? S_DONE : S_FL_FAIL;
			end
			K_INV: drop_range(r.device_id, r.lba, r.num_sectors);
			default: ;
		endcase
		return a;
	endfunction

	function automatic dir_request_t make_request(logic [KIND_W-1:0] k,
			logic [DEV_W-1:0] dev, logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt,
			logic [SLOT_W-1:0] sl, logic ok);
		dir_request_t r;
		r.kind = k;
		r.device_id = dev;
		r.lba = lba;
		r.num_sectors = cnt;
		r.slot = sl;
		r.io_ok = ok;
		return r;
	endfunction

	// random request; a small working set keeps hits, fills and flushes frequent
	function automatic dir_request_t random_request(logic [LBA_W-1:0] base);
		dir_request_t r;
		int pick;
		r.kind = KIND_W'($urandom_range(0, 7));
		pick = $urandom_range(0, 9);
		r.device_id = (pick < 8) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
		r.lba = (pick < 8) ? base + LBA_W'($urandom_range(0, 95)) : LBA_W'($urandom);
		pick = $urandom_range(0, 9);
		r.num_sectors = (pick < 6) ? CNT_W'(1) : (pick < 9) ? CNT_W'($urandom_range(0, 8))
			: CNT_W'($urandom);
		r.slot = SLOT_W'($urandom);
		r.io_ok = ($urandom_range(0, 3) != 0);
		return r;
	endfunction

	task automatic queue_request(dir_request_t r);
		pending_requests.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ENABLE)
			shadow_enable = val[0];
		else
			shadow_threshold = val;
		@(posedge clk);
	endtask

	// drive requests: one transaction at a time with a random gap between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= '0;
			req_ch.device_id <= '0;
			req_ch.lba <= '0;
			req_ch.num_sectors <= '0;
			req_ch.slot <= '0;
			req_ch.io_ok <= 1'b0;
			send_wait <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
			// hold the offered transaction
		end else begin
			if (req_ch.valid) begin
				expected_answers.push_back(predict_answer(pending_requests.pop_front()));
				sent_count <= sent_count + 1;
			end
			if (send_wait > 0) begin
				send_wait <= send_wait - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				dir_request_t nx;
				nx = pending_requests[0];
				req_ch.valid <= 1'b1;
				{req_ch.kind, req_ch.device_id, req_ch.lba, req_ch.num_sectors,
					req_ch.slot, req_ch.io_ok} <= nx;
				send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// accept and check answers; ready follows a random stall count per transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			take_wait <= 0;
			hold_off <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				dir_answer_t got;
				dir_answer_t want;
				got = {rsp_ch.status, rsp_ch.entry_slot, rsp_ch.flush_device,
					rsp_ch.flush_lba};
				answer_count <= answer_count + 1;
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected answer %h", $time, got);
					errors++;
				end else begin
					want = expected_answers.pop_front();
					if (got.status == S_HIT)
						hit_count <= hit_count + 1;
					if (got.status == S_FL_START)
						flush_count <= flush_count + 1;
					if (got.status != want.status)
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
					if (got.entry_slot != want.entry_slot)
						$display("%0t: entry_slot expected %0d actual %0d", $time,
							want.entry_slot, got.entry_slot);
					if (got.flush_device != want.flush_device)
						$display("%0t: flush_device expected %0d actual %0d", $time,
							want.flush_device, got.flush_device);
					if (got.flush_lba != want.flush_lba)
						$display("%0t: flush_lba expected %h actual %h", $time,
							want.flush_lba, got.flush_lba);
					if (got != want)
						errors++;
				end
			end
			if (hold_armed && hold_off == 0) begin
				hold_off <= LONG_STALL;
				hold_armed <= 1'b0;
				rsp_ch.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_ch.valid && rsp_ch.ready) begin
				take_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				rsp_ch.ready <= 1'b0;
			end else if (take_wait > 0) begin
				take_wait <= take_wait - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| hold_off > 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("testbench failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [LBA_W-1:0] base;
		errors = 0;
		sent_count = 0;
		answer_count = 0;
		hit_count = 0;
		flush_count = 0;
		idle_cycles = 0;
		hold_armed = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			dir_valid[i] = 1'b0;
			dir_dirty[i] = 1'b0;
			dir_flushing[i] = 1'b0;
			dir_rewritten[i] = 1'b0;
			dir_dev[i] = '0;
			dir_sector[i] = '0;
			dir_age[i] = '0;
		end
		for (int d = 0; d < DEVICES; d++) begin
			seq_seen[d] = 1'b0;
			seq_run[d] = '0;
			seq_end[d] = '0;
		end
		cursor = '0;
		lru_clock = '0;
		shadow_enable = 1'b1;
		shadow_threshold = SEQ_THR_RESET;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, field extremes, rewrite during flush, wrap ranges
		queue_request(make_request(K_RD_LOOKUP, 5'd0, 32'h0, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_RD_FILL, 5'd31, 32'hFFFF_FFFF, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_RD_LOOKUP, 5'd31, 32'hFFFF_FFFF, 8'd0, 6'd0, 1'b0));
		queue_request(make_request(K_RD_FILL, 5'd31, 32'hFFFF_FFFF, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd1, 32'h100, 8'd0, 6'd0, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd1, 32'h100, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd1, 32'h101, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_FL_PICK, 5'd0, 32'h0, 8'd0, 6'd0, 1'b1));
		queue_request(make_request(K_WR_RETRY, 5'd1, 32'h100, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_FL_DONE, 5'd0, 32'h0, 8'd0, 6'd1, 1'b1));
		queue_request(make_request(K_FL_PICK, 5'd0, 32'h0, 8'd0, 6'd0, 1'b1));
		queue_request(make_request(K_FL_DONE, 5'd0, 32'h0, 8'd0, 6'd1, 1'b0));
		queue_request(make_request(K_FL_DONE, 5'd0, 32'h0, 8'd0, 6'd63, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd1, 32'h102, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd1, 32'h103, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd2, 32'hFFFF_FFFE, 8'd255, 6'd0, 1'b1));
		queue_request(make_request(K_INV, 5'd31, 32'hFFFF_FFF0, 8'd255, 6'd0, 1'b1));
		queue_request(make_request(K_INV, 5'd1, 32'h100, 8'd0, 6'd0, 1'b1));
		queue_request(make_request(K_FL_PICK, 5'd0, 32'h0, 8'd0, 6'd0, 1'b1));
		queue_request(make_request(3'd7, 5'd0, 32'h0, 8'd0, 6'd0, 1'b0));
		wait_idle();

		// fill the directory with dirty sectors so installs report full
		write_register(CFG_SEQ_THR, 16'hFFFF);
		for (int i = 0; i < ENTRIES + 4; i++)
			queue_request(make_request(K_WR_RETRY, 5'd3, 32'h4000 + i, 8'd1,
				6'd0, 1'b1));
		queue_request(make_request(K_RD_FILL, 5'd3, 32'h9000, 8'd1, 6'd0, 1'b1));
		queue_request(make_request(K_WR_REQ, 5'd3, 32'h9000, 8'd1, 6'd0, 1'b1));
		wait_idle();

		// random phases over several register settings; one long response stall
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_register(CFG_ENABLE, 16'd1);
					write_register(CFG_SEQ_THR, 16'd1);
				end
				1: write_register(CFG_SEQ_THR, 16'd4);
				2: write_register(CFG_ENABLE, 16'd0);
				3: begin
					write_register(CFG_ENABLE, 16'd1);
					write_register(CFG_SEQ_THR, 16'hFFFF);
				end
				4: write_register(CFG_SEQ_THR, 16'($urandom_range(2, 12)));
				default: write_register(CFG_SEQ_THR, 16'($urandom));
			endcase
			if (phase == 1)
				hold_armed = 1'b1;
			base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFC0 : LBA_W'($urandom);
			for (int n = 0; n < 130; n++)
				queue_request(random_request(base));
			wait_idle();
		end

		$display("sent %0d requests, checked %0d answers (%0d hits, %0d flushes)",
			sent_count, answer_count, hit_count, flush_count);
		$display("covered lookups, fills, writes, retries, flushes, invalidation, "
			, "bypass and a long response stall");
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
